// ===== src/gregorian_date_arithmetic_unit_assert.svh =====
// assertion macros for the gregorian date unit
// expects clk_i and rst_ni in the including module
`ifndef GREGORIAN_DATE_ARITHMETIC_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_UNIT_ASSERT_SVH

// property holds at every edge out of reset
`define GDAU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition now implies expression at the next edge
`define GDAU_ASSERT_NEXT(name, cond, nxt, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== src/gdau_pkg.sv =====
// shared types, constants and calendar period lengths for the date unit
// no dependencies
`default_nettype none

package gdau_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned ACTION_W = 2;

  localparam int unsigned DEF_OFFSET_WIDTH = 21;
  localparam int unsigned DEF_DIFF_WIDTH   = 23;
  localparam int unsigned DEF_ACC_W        = 25;

  // days in 400 years, and days from year 0 up to year 10000
  localparam logic [17:0]       CYCLE_DAYS = 18'd146097;
  localparam logic [21:0]       SERIAL_END = 22'd3652425;
  localparam logic [YEAR_W-1:0] YEAR_LIMIT = 14'd10000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_CMP  = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // year position inside a 400 year cycle: century k, four-year block j, year i
  function automatic logic leap_at(logic [1:0] k, logic [4:0] j, logic [1:0] i);
    return (i == 2'd0) && ((j != 5'd0) || (k == 2'd0));
  endfunction

  function automatic logic [15:0] cent_days(logic [1:0] k);
    return (k == 2'd0) ? 16'd36525 : 16'd36524;
  endfunction

  function automatic logic [10:0] quad_days(logic [1:0] k, logic [4:0] j);
    return ((j == 5'd0) && (k != 2'd0)) ? 11'd1460 : 11'd1461;
  endfunction

  function automatic logic [8:0] year_days(logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(logic leap, logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/gdau_alu.sv =====
// shared add/subtract unit of the date sequencer, with sign of the result
// depends on gdau_pkg
`default_nettype none

module gdau_alu import gdau_pkg::*; #(
  parameter int unsigned Width = DEF_ACC_W
) (
  input  logic signed [Width-1:0] a_i,
  input  logic signed [Width-1:0] b_i,
  input  alu_op_e                 op_i,
  output logic signed [Width-1:0] sum_o,
  output logic                    neg_o
);

  always_comb begin
    unique case (op_i)
      ALU_ADD: sum_o = a_i + b_i;
      ALU_SUB: sum_o = a_i - b_i;
    endcase
  end

  assign neg_o = sum_o[Width-1];

endmodule

`default_nettype wire

// ===== src/gregorian_date_arithmetic_unit.sv =====
// gregorian date unit: stored date, load / add days / compare with difference
// depends on gdau_pkg, gdau_alu and gregorian_date_arithmetic_unit_assert.svh
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | start_i, busy_o    | action_i, date_*_i, day_offset_i
//  result    | done_o (strobe)    | cur_*_out_o, flags, day_difference_o
//
// in a request the shared adder walks 400-year, century, four-year, year and
// month periods one per cycle, once per date converted to a day count and once
// more when a day count goes back to a date
// busy_o is high from acceptance until the result strobe; reset clears to idle
// with the stored date at 1900-01-01; the result shows for one cycle on done_o
`default_nettype none

`include "gregorian_date_arithmetic_unit_assert.svh"

module gregorian_date_arithmetic_unit import gdau_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = DEF_OFFSET_WIDTH,
  parameter int unsigned DIFF_WIDTH   = DEF_DIFF_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [ACTION_W-1:0]          action_i,
  input  logic [YEAR_W-1:0]            date_year_i,
  input  logic [MONTH_W-1:0]           date_month_i,
  input  logic [DAY_W-1:0]             date_day_i,
  input  logic signed [OFFSET_WIDTH-1:0] day_offset_i,
  output logic                         done_o,
  output logic [YEAR_W-1:0]            cur_year_out_o,
  output logic [MONTH_W-1:0]           cur_month_out_o,
  output logic [DAY_W-1:0]             cur_day_out_o,
  output logic                         illegal_date_o,
  output logic                         range_error_o,
  output logic                         is_greater_o,
  output logic                         is_equal_o,
  output logic signed [DIFF_WIDTH-1:0] day_difference_o
);

  localparam int unsigned WideW = (OFFSET_WIDTH > DIFF_WIDTH) ? OFFSET_WIDTH : DIFF_WIDTH;
  localparam int unsigned AccW  = ((WideW > 24) ? WideW : 24) + 1;

  localparam logic signed [AccW-1:0] DiffHi =
    {{(AccW - DIFF_WIDTH + 1){1'b0}}, {(DIFF_WIDTH - 1){1'b1}}};
  localparam logic signed [AccW-1:0] DiffLo =
    {{(AccW - DIFF_WIDTH + 1){1'b1}}, {(DIFF_WIDTH - 1){1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_Y400 = 4'd1;
  localparam logic [3:0] S_Y100 = 4'd2;
  localparam logic [3:0] S_Y4   = 4'd3;
  localparam logic [3:0] S_Y1   = 4'd4;
  localparam logic [3:0] S_MON  = 4'd5;
  localparam logic [3:0] S_OFF  = 4'd6;
  localparam logic [3:0] S_RNG  = 4'd7;
  localparam logic [3:0] S_F400 = 4'd8;
  localparam logic [3:0] S_F100 = 4'd9;
  localparam logic [3:0] S_F4   = 4'd10;
  localparam logic [3:0] S_F1   = 4'd11;
  localparam logic [3:0] S_FMON = 4'd12;
  localparam logic [3:0] S_DIFF = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  // control state
  logic [3:0]         state_q, state_d;
  action_e            act_q, act_d;
  logic               pass_q, pass_d;
  logic               ybig_q, ybig_d;
  logic               illegal_q, illegal_d;
  logic               range_q, range_d;
  logic               done_q, done_d;
  logic [YEAR_W-1:0]  cur_year_q, cur_year_d;
  logic [MONTH_W-1:0] cur_month_q, cur_month_d;
  logic [DAY_W-1:0]   cur_day_q, cur_day_d;

  // datapath
  logic signed [AccW-1:0]         acc_q, acc_d;
  logic signed [AccW-1:0]         sg_q, sg_d;
  logic [YEAR_W-1:0]              yrem_q, yrem_d;
  logic [MONTH_W-1:0]             tm_q, tm_d;
  logic [DAY_W-1:0]               td_q, td_d;
  logic [YEAR_W-1:0]              gy_q, gy_d;
  logic [MONTH_W-1:0]             gm_q, gm_d;
  logic [DAY_W-1:0]               gd_q, gd_d;
  logic signed [OFFSET_WIDTH-1:0] off_q, off_d;
  logic [4:0]                     c_q, c_d;
  logic [1:0]                     k_q, k_d;
  logic [4:0]                     j_q, j_d;
  logic [1:0]                     i_q, i_d;
  logic [MONTH_W-1:0]             mon_q, mon_d;

  // result register
  logic [YEAR_W-1:0]             res_year_q;
  logic [MONTH_W-1:0]            res_month_q;
  logic [DAY_W-1:0]              res_day_q;
  logic                          res_illegal_q;
  logic                          res_range_q;
  logic                          res_gt_q;
  logic                          res_eq_q;
  logic signed [DIFF_WIDTH-1:0]  res_diff_q;

  logic signed [AccW-1:0] alu_b;
  alu_op_e                alu_op;
  logic signed [AccW-1:0] alu_sum;
  logic                   alu_neg;

  logic                          leap;
  logic                          date_ok;
  logic [YEAR_W-1:0]             year_calc;
  logic                          cmp_gt;
  logic                          cmp_eq;
  logic signed [DIFF_WIDTH-1:0]  diff_sat;

  gdau_alu #(
    .Width (AccW)
  ) u_alu (
    .a_i   (acc_q),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .sum_o (alu_sum),
    .neg_o (alu_neg)
  );

  assign leap    = leap_at(k_q, j_q, i_q);
  assign date_ok = (tm_q >= 4'd1) && (tm_q <= 4'd12) && (td_q != 5'd0) &&
                   (td_q <= month_days(leap, tm_q));
  assign year_calc = YEAR_W'(c_q) * 14'd400 + YEAR_W'(k_q) * 14'd100 +
                     {7'd0, j_q, 2'd0} + YEAR_W'(i_q);

  // period length, day offset, range limit or first day count fed to the shared adder
  always_comb begin
    alu_b  = '0;
    alu_op = ALU_ADD;
    unique case (state_q)
      S_Y400:  alu_b = AccW'(CYCLE_DAYS);
      S_Y100:  alu_b = AccW'(cent_days(k_q));
      S_Y4:    alu_b = AccW'(quad_days(k_q, j_q));
      S_Y1:    alu_b = AccW'(year_days(leap));
      S_MON:   alu_b = AccW'(month_days(leap, mon_q));
      S_OFF:   alu_b = {{(AccW - OFFSET_WIDTH){off_q[OFFSET_WIDTH-1]}}, off_q};
      S_RNG: begin
        alu_b  = AccW'(SERIAL_END);
        alu_op = ALU_SUB;
      end
      S_F400: begin
        alu_b  = AccW'(CYCLE_DAYS);
        alu_op = ALU_SUB;
      end
      S_F100: begin
        alu_b  = AccW'(cent_days(k_q));
        alu_op = ALU_SUB;
      end
      S_F4: begin
        alu_b  = AccW'(quad_days(k_q, j_q));
        alu_op = ALU_SUB;
      end
      S_F1: begin
        alu_b  = AccW'(year_days(leap));
        alu_op = ALU_SUB;
      end
      S_FMON: begin
        alu_b  = AccW'(month_days(leap, mon_q));
        alu_op = ALU_SUB;
      end
      S_DIFF: begin
        alu_b  = sg_q;
        alu_op = ALU_SUB;
      end
      default: begin
        alu_b  = '0;
        alu_op = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    pass_d      = pass_q;
    ybig_d      = ybig_q;
    illegal_d   = illegal_q;
    range_d     = range_q;
    done_d      = 1'b0;
    cur_year_d  = cur_year_q;
    cur_month_d = cur_month_q;
    cur_day_d   = cur_day_q;
    acc_d       = acc_q;
    sg_d        = sg_q;
    yrem_d      = yrem_q;
    tm_d        = tm_q;
    td_d        = td_q;
    gy_d        = gy_q;
    gm_d        = gm_q;
    gd_d        = gd_q;
    off_d       = off_q;
    c_d         = c_q;
    k_d         = k_q;
    j_d         = j_q;
    i_d         = i_q;
    mon_d       = mon_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d     = action_e'(action_i);
          gy_d      = date_year_i;
          gm_d      = date_month_i;
          gd_d      = date_day_i;
          off_d     = day_offset_i;
          illegal_d = 1'b0;
          range_d   = 1'b0;
          pass_d    = 1'b0;
          k_d       = '0;
          j_d       = '0;
          i_d       = '0;
          mon_d     = 4'd1;
          unique case (action_e'(action_i))
            ACT_LOAD, ACT_CMP: begin
              yrem_d  = date_year_i;
              tm_d    = date_month_i;
              td_d    = date_day_i;
              ybig_d  = (date_year_i >= YEAR_LIMIT);
              acc_d   = AccW'(date_day_i) - AccW'(1);
              state_d = S_Y400;
            end
            ACT_ADD: begin
              yrem_d  = cur_year_q;
              tm_d    = cur_month_q;
              td_d    = cur_day_q;
              ybig_d  = 1'b0;
              acc_d   = AccW'(cur_day_q) - AccW'(1);
              state_d = S_Y400;
            end
            ACT_NOP: state_d = S_OUT;
          endcase
        end
      end

      // date to day count: consume whole periods of the year count
      S_Y400: begin
        if (yrem_q >= 14'd400) begin
          acc_d  = alu_sum;
          yrem_d = yrem_q - 14'd400;
        end else begin
          state_d = S_Y100;
        end
      end
      S_Y100: begin
        if (yrem_q >= 14'd100) begin
          acc_d  = alu_sum;
          yrem_d = yrem_q - 14'd100;
          k_d    = k_q + 2'd1;
        end else begin
          state_d = S_Y4;
        end
      end
      S_Y4: begin
        if (yrem_q >= 14'd4) begin
          acc_d  = alu_sum;
          yrem_d = yrem_q - 14'd4;
          j_d    = j_q + 5'd1;
        end else begin
          state_d = S_Y1;
        end
      end
      S_Y1: begin
        if (yrem_q != '0) begin
          acc_d  = alu_sum;
          yrem_d = yrem_q - 14'd1;
          i_d    = i_q + 2'd1;
        end else begin
          // leap of the target year is known here
          unique case (act_q)
            ACT_LOAD: begin
              illegal_d = !date_ok;
              range_d   = ybig_q;
              if (!ybig_q) begin
                cur_year_d  = gy_q;
                cur_month_d = gm_q;
                cur_day_d   = gd_q;
              end
              state_d = S_OUT;
            end
            ACT_ADD, ACT_CMP: begin
              if (!date_ok || ybig_q) begin
                illegal_d = 1'b1;
                state_d   = S_OUT;
              end else begin
                mon_d   = 4'd1;
                state_d = S_MON;
              end
            end
            ACT_NOP: state_d = S_OUT;
          endcase
        end
      end
      S_MON: begin
        if (mon_q < tm_q) begin
          acc_d = alu_sum;
          mon_d = mon_q + 4'd1;
        end else begin
          priority if (act_q == ACT_ADD) begin
            state_d = S_OFF;
          end else if (!pass_q) begin
            // given date done, now the stored one
            sg_d    = acc_q;
            yrem_d  = cur_year_q;
            tm_d    = cur_month_q;
            td_d    = cur_day_q;
            ybig_d  = 1'b0;
            acc_d   = AccW'(cur_day_q) - AccW'(1);
            k_d     = '0;
            j_d     = '0;
            i_d     = '0;
            mon_d   = 4'd1;
            pass_d  = 1'b1;
            state_d = S_Y400;
          end else begin
            state_d = S_DIFF;
          end
        end
      end
      S_OFF: begin
        acc_d   = alu_sum;
        state_d = S_RNG;
      end
      S_RNG: begin
        if (acc_q[AccW-1] || !alu_neg) begin
          range_d = 1'b1;
          state_d = S_OUT;
        end else begin
          c_d     = '0;
          k_d     = '0;
          j_d     = '0;
          i_d     = '0;
          mon_d   = 4'd1;
          state_d = S_F400;
        end
      end

      // day count back to a date: strip whole periods while they fit
      S_F400: begin
        if (!alu_neg) begin
          acc_d = alu_sum;
          c_d   = c_q + 5'd1;
        end else begin
          state_d = S_F100;
        end
      end
      S_F100: begin
        if (!alu_neg) begin
          acc_d = alu_sum;
          k_d   = k_q + 2'd1;
        end else begin
          state_d = S_F4;
        end
      end
      S_F4: begin
        if (!alu_neg) begin
          acc_d = alu_sum;
          j_d   = j_q + 5'd1;
        end else begin
          state_d = S_F1;
        end
      end
      S_F1: begin
        if (!alu_neg) begin
          acc_d = alu_sum;
          i_d   = i_q + 2'd1;
        end else begin
          state_d = S_FMON;
        end
      end
      S_FMON: begin
        if ((mon_q < 4'd12) && !alu_neg) begin
          acc_d = alu_sum;
          mon_d = mon_q + 4'd1;
        end else begin
          cur_year_d  = year_calc;
          cur_month_d = mon_q;
          cur_day_d   = acc_q[DAY_W-1:0] + 5'd1;
          state_d     = S_OUT;
        end
      end
      S_DIFF: begin
        acc_d   = alu_sum;
        state_d = S_OUT;
      end
      S_OUT: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmp_eq = (cur_year_q == gy_q) && (cur_month_q == gm_q) && (cur_day_q == gd_q);
    priority if (cur_year_q != gy_q) begin
      cmp_gt = (cur_year_q > gy_q);
    end else if (cur_month_q != gm_q) begin
      cmp_gt = (cur_month_q > gm_q);
    end else begin
      cmp_gt = (cur_day_q > gd_q);
    end
  end

  always_comb begin
    priority if (acc_q > DiffHi) begin
      diff_sat = DiffHi[DIFF_WIDTH-1:0];
    end else if (acc_q < DiffLo) begin
      diff_sat = DiffLo[DIFF_WIDTH-1:0];
    end else begin
      diff_sat = acc_q[DIFF_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_NOP;
      pass_q      <= 1'b0;
      ybig_q      <= 1'b0;
      illegal_q   <= 1'b0;
      range_q     <= 1'b0;
      done_q      <= 1'b0;
      cur_year_q  <= 14'd1900;
      cur_month_q <= 4'd1;
      cur_day_q   <= 5'd1;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      pass_q      <= pass_d;
      ybig_q      <= ybig_d;
      illegal_q   <= illegal_d;
      range_q     <= range_d;
      done_q      <= done_d;
      cur_year_q  <= cur_year_d;
      cur_month_q <= cur_month_d;
      cur_day_q   <= cur_day_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    sg_q   <= sg_d;
    yrem_q <= yrem_d;
    tm_q   <= tm_d;
    td_q   <= td_d;
    gy_q   <= gy_d;
    gm_q   <= gm_d;
    gd_q   <= gd_d;
    off_q  <= off_d;
    c_q    <= c_d;
    k_q    <= k_d;
    j_q    <= j_d;
    i_q    <= i_d;
    mon_q  <= mon_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      res_year_q    <= cur_year_q;
      res_month_q   <= cur_month_q;
      res_day_q     <= cur_day_q;
      res_illegal_q <= illegal_q;
      res_range_q   <= range_q;
      res_gt_q      <= (act_q == ACT_CMP) && cmp_gt;
      res_eq_q      <= (act_q == ACT_CMP) && cmp_eq;
      res_diff_q    <= ((act_q == ACT_CMP) && !illegal_q) ? diff_sat : '0;
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign cur_year_out_o   = res_year_q;
  assign cur_month_out_o  = res_month_q;
  assign cur_day_out_o    = res_day_q;
  assign illegal_date_o   = res_illegal_q;
  assign range_error_o    = res_range_q;
  assign is_greater_o     = res_gt_q;
  assign is_equal_o       = res_eq_q;
  assign day_difference_o = res_diff_q;

  `GDAU_ASSERT_NEXT(a_start_goes_busy, start_i && !busy_o, busy_o, "accepted request left unit idle")
  `GDAU_ASSERT(a_year_in_range, cur_year_q < YEAR_LIMIT, "stored year beyond 9999")
  `GDAU_ASSERT_NEXT(a_idle_keeps_date, state_q == S_IDLE, $stable(cur_year_q) && $stable(cur_month_q) && $stable(cur_day_q), "stored date changed while idle")
  `GDAU_ASSERT(a_gt_eq_excl, done_q |-> !(res_gt_q && res_eq_q), "greater and equal both set")
  `GDAU_ASSERT(a_equal_zero_diff, (done_q && res_eq_q) |-> (res_diff_q == '0), "equal dates with nonzero difference")

endmodule

`default_nettype wire
